// File: hdl/q32a_pkg.sv
// ----------------------------------------------------------------------------
// q32a_pkg
// Shared types, constants and helpers for the Q32.32 arithmetic unit.
// ----------------------------------------------------------------------------
package q32a_pkg;

  typedef enum logic [1:0] {
    CMD_ADD  = 2'd0,
    CMD_MUL  = 2'd1,
    CMD_MAC  = 2'd2,
    CMD_EMIT = 2'd3
  } cmd_e_t;

  // status flag bit positions
  localparam int FLG_SAT   = 0;
  localparam int FLG_TRUNC = 1;
  localparam int FLG_DIVZ  = 2;
  localparam int FLG_RANGE = 3;
  localparam int FLG_CROP  = 4;

  localparam int FLG_W     = 5;
  localparam int CNT_W     = 31;
  localparam int DIV_BITS  = 31;            // quotient bits resolved, one per stage
  localparam int STAGE_CNT = DIV_BITS + 1;  // registered stages inside each unit
  localparam int MUL_STAGES = 6;

  localparam logic [63:0] I64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] I64_MIN = 64'h8000_0000_0000_0000;
  localparam logic [CNT_W-1:0] EMIT_CAP_RST = '1;

  typedef struct packed {
    logic [63:0] val;
    logic        sat;
  } sum_t;

  // results of the add / multiply / multiply-accumulate path
  typedef struct packed {
    logic [63:0]      add_val;
    logic [FLG_W-1:0] add_flg;
    logic [63:0]      mul_val;
    logic [FLG_W-1:0] mul_flg;
    logic [63:0]      mac_val;
    logic [FLG_W-1:0] mac_flg;
  } arith_res_t;

  typedef struct packed {
    logic [63:0]      val;
    logic [CNT_W-1:0] count;
    logic [FLG_W-1:0] flg;
  } emit_res_t;

  function automatic sum_t sat_add(input logic [63:0] a, input logic [63:0] b);
    sum_t        r;
    logic [63:0] s;
    s = a + b;
    if ((a[63] == b[63]) && (s[63] != a[63])) begin
      r.val = a[63] ? I64_MIN : I64_MAX;
      r.sat = 1'b1;
    end else begin
      r.val = s;
      r.sat = 1'b0;
    end
    return r;
  endfunction

endpackage

// File: hdl/q32a_if.sv
// ----------------------------------------------------------------------------
// q32a interfaces
// Valid/ready channels for operations, results and the emit cap register.
// ----------------------------------------------------------------------------
interface q32a_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic signed [63:0] operand_a;
  logic signed [63:0] operand_b;
  logic signed [63:0] addend;
  modport source (output valid, command, operand_a, operand_b, addend, input ready);
  modport sink   (input valid, command, operand_a, operand_b, addend, output ready);
endinterface

interface q32a_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] result_value;
  logic [30:0]        emit_count;
  logic [4:0]         status_flags;
  modport source (output valid, result_value, emit_count, status_flags, input ready);
  modport sink   (input valid, result_value, emit_count, status_flags, output ready);
endinterface

interface q32a_cfg_if;
  logic        valid;
  logic        ready;
  logic [30:0] max_emit;
  modport source (output valid, max_emit, input ready);
  modport sink   (input valid, max_emit, output ready);
endinterface

// File: hdl/q32a_mul.sv
// ----------------------------------------------------------------------------
// q32a_mul
// Pipelined saturating add, Q32.32 multiply (round to nearest even) and MAC.
// ----------------------------------------------------------------------------
module q32a_mul (
  input  logic                 clk,
  input  logic                 en,
  input  logic [63:0]          a,
  input  logic [63:0]          b,
  input  logic [63:0]          acc,
  output q32a_pkg::arith_res_t res
);
  import q32a_pkg::*;

  localparam int PAD = STAGE_CNT - MUL_STAGES;

  logic [63:0]  ma_r, mb_r;
  logic         neg_r;
  logic [63:0]  acc_r [MUL_STAGES-1];
  arith_res_t   s_r   [MUL_STAGES];
  logic [63:0]  p00_r, p01_r, p10_r, p11_r;
  logic [127:0] prod_r, sprod_r;
  logic         neg1_r, neg2_r;
  arith_res_t   pad_r [PAD];

  sum_t         add_s, mac_s;
  logic [95:0]  q_sum;
  logic         inc, trunc;
  arith_res_t   r0_nxt, r4_nxt, r5_nxt;

  always_comb begin
    add_s          = sat_add(a, b);
    r0_nxt         = '0;
    r0_nxt.add_val = add_s.val;
    r0_nxt.add_flg = FLG_W'(add_s.sat) << FLG_SAT;
  end

  // round: guard, round, sticky and lsb of the kept part
  always_comb begin
    inc   = sprod_r[31] & (sprod_r[30] | (|sprod_r[29:0]) | sprod_r[32]);
    trunc = |sprod_r[31:0];
    q_sum = sprod_r[127:32] + {95'b0, inc};
    r4_nxt = s_r[3];
    r4_nxt.mul_flg = '0;
    r4_nxt.mul_flg[FLG_TRUNC] = trunc;
    if ((&q_sum[95:63]) || !(|q_sum[95:63])) begin
      r4_nxt.mul_val = q_sum[63:0];
    end else begin
      r4_nxt.mul_val = q_sum[95] ? I64_MIN : I64_MAX;
      r4_nxt.mul_flg[FLG_SAT] = 1'b1;
    end
  end

  always_comb begin
    mac_s  = sat_add(acc_r[MUL_STAGES-2], s_r[4].mul_val);
    r5_nxt = s_r[4];
    r5_nxt.mac_val = mac_s.val;
    r5_nxt.mac_flg = s_r[4].mul_flg | (FLG_W'(mac_s.sat) << FLG_SAT);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 0: magnitudes, sign, add
      ma_r   <= a[63] ? (64'd0 - a) : a;
      mb_r   <= b[63] ? (64'd0 - b) : b;
      neg_r  <= a[63] ^ b[63];
      s_r[0] <= r0_nxt;
      acc_r[0] <= acc;
      // stage 1: partial products
      p00_r  <= {32'b0, ma_r[31:0]}  * {32'b0, mb_r[31:0]};
      p01_r  <= {32'b0, ma_r[31:0]}  * {32'b0, mb_r[63:32]};
      p10_r  <= {32'b0, ma_r[63:32]} * {32'b0, mb_r[31:0]};
      p11_r  <= {32'b0, ma_r[63:32]} * {32'b0, mb_r[63:32]};
      neg1_r <= neg_r;
      s_r[1] <= s_r[0];
      acc_r[1] <= acc_r[0];
      // stage 2: sum partial products
      prod_r <= {64'b0, p00_r} + {32'b0, p01_r, 32'b0} + {32'b0, p10_r, 32'b0}
              + {p11_r, 64'b0};
      neg2_r <= neg1_r;
      s_r[2] <= s_r[1];
      acc_r[2] <= acc_r[1];
      // stage 3: apply sign
      sprod_r <= neg2_r ? (128'd0 - prod_r) : prod_r;
      s_r[3]  <= s_r[2];
      acc_r[3] <= acc_r[2];
      // stage 4: round and saturate
      s_r[4]  <= r4_nxt;
      acc_r[4] <= acc_r[3];
      // stage 5: accumulate
      s_r[5]  <= r5_nxt;
    end
  end

  // align with the emit unit
  always_ff @(posedge clk) begin
    if (en) begin
      pad_r[0] <= s_r[MUL_STAGES-1];
      for (int i = 1; i < PAD; i++) begin
        pad_r[i] <= pad_r[i-1];
      end
    end
  end

  assign res = pad_r[PAD-1];

endmodule

// File: hdl/q32a_emit.sv
// ----------------------------------------------------------------------------
// q32a_emit
// Step-emit: restoring divider, one quotient bit per stage, capped count.
// ----------------------------------------------------------------------------
module q32a_emit (
  input  logic                          clk,
  input  logic                          en,
  input  logic [63:0]                   x,
  input  logic [63:0]                   theta,
  input  logic [q32a_pkg::CNT_W-1:0]    cap,
  output q32a_pkg::emit_res_t           res
);
  import q32a_pkg::*;

  typedef struct packed {
    logic [63:0]      x;
    logic [62:0]      theta;
    logic [CNT_W-1:0] cap;
    logic             divz;
    logic             rng;
    logic             over;
    logic [62:0]      rem;
    logic [CNT_W-1:0] quo;
    logic [62:0]      mprod;
  } emit_stg_t;

  emit_stg_t   e0_r, e0_nxt;
  logic [62:0] plo_r, plo_nxt;
  logic [61:0] phi_r, phi_nxt;
  emit_stg_t   stg_r [DIV_BITS];

  always_comb begin
    e0_nxt       = '0;
    e0_nxt.x     = x;
    e0_nxt.theta = theta[62:0];
    e0_nxt.cap   = cap;
    e0_nxt.divz  = theta[63] | (theta == 64'd0);
    e0_nxt.rng   = !e0_nxt.divz & x[63];
    // quotient at least 2^31 exactly when x / 2^31 >= theta
    e0_nxt.over  = {31'b0, x[62:31]} >= theta[62:0];
    e0_nxt.rem   = (e0_nxt.divz | e0_nxt.rng) ? 63'd0 : x[62:0];
    plo_nxt      = {32'b0, cap} * {31'b0, theta[31:0]};
    phi_nxt      = {31'b0, cap} * {31'b0, theta[62:32]};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e0_r  <= e0_nxt;
      plo_r <= plo_nxt;
      phi_r <= phi_nxt;
    end
  end

  for (genvar i = 0; i < DIV_BITS; i++) begin : g_div
    localparam int K = DIV_BITS - 1 - i;
    emit_stg_t   prv, nxt;
    logic [62:0] shr;
    logic        take;

    if (i == 0) begin : g_first
      always_comb begin
        prv       = e0_r;
        prv.mprod = plo_r + {phi_r[30:0], 32'b0};
      end
    end else begin : g_rest
      assign prv = stg_r[i-1];
    end

    always_comb begin
      shr  = prv.rem >> K;
      take = shr >= prv.theta;
      nxt  = prv;
      if (take) begin
        nxt.rem    = prv.rem - (prv.theta << K);
        nxt.quo[K] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stg_r[i] <= nxt;
      end
    end
  end

  // clip to the cap; remainder from the cap product when cropped
  always_comb begin
    emit_stg_t l;
    logic      ok, crop;
    l    = stg_r[DIV_BITS-1];
    ok   = !l.divz & !l.rng;
    crop = ok & (l.over | (l.quo > l.cap));
    res  = '0;
    res.flg[FLG_DIVZ]  = l.divz;
    res.flg[FLG_RANGE] = l.rng;
    res.flg[FLG_CROP]  = crop;
    if (!ok) begin
      res.val = l.x;
    end else if (crop) begin
      res.val   = {1'b0, l.x[62:0] - l.mprod};
      res.count = l.cap;
    end else begin
      res.val   = {1'b0, l.rem};
      res.count = l.quo;
    end
  end

endmodule

// File: hdl/q32_fixed_point_alu.sv
// ----------------------------------------------------------------------------
// q32_fixed_point_alu
// Signed Q32.32 add, multiply, multiply-accumulate and step-emit unit.
// ----------------------------------------------------------------------------
// Depth: 32 unit stages plus the output register between input beat and result
//   beat; the 31-stage restoring divider of emit sets the depth.
// Throughput: one beat per cycle; a stalled output freezes the whole pipeline.
// Reset (rst_n, synchronous): valid bits clear, max_emit returns to 2^31-1.
// ----------------------------------------------------------------------------
module q32_fixed_point_alu (
  input  logic  clk,
  input  logic  rst_n,
  q32a_in_if.sink     in_ch,
  q32a_out_if.source  out_ch,
  q32a_cfg_if.sink    cfg_ch
);
  import q32a_pkg::*;

  logic                 adv;
  logic [CNT_W-1:0]     max_emit_r;
  logic [STAGE_CNT-1:0] vld_r;
  cmd_e_t               cmd_r [STAGE_CNT];
  arith_res_t           ar;
  emit_res_t            er;
  logic                 out_vld_r;
  logic [63:0]          val_r, val_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [FLG_W-1:0]     flg_r, flg_nxt;

  // advance when the output register is empty or being taken
  assign adv          = !out_vld_r || out_ch.ready;
  assign in_ch.ready  = adv;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_emit_r <= EMIT_CAP_RST;
    end else if (cfg_ch.valid) begin
      max_emit_r <= cfg_ch.max_emit;
    end
  end

  q32a_mul u_mul (
    .clk (clk),
    .en  (adv),
    .a   (in_ch.operand_a),
    .b   (in_ch.operand_b),
    .acc (in_ch.addend),
    .res (ar)
  );

  q32a_emit u_emit (
    .clk   (clk),
    .en    (adv),
    .x     (in_ch.operand_a),
    .theta (in_ch.operand_b),
    .cap   (max_emit_r),
    .res   (er)
  );

  // valid bits and command travel alongside the unit pipelines
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      vld_r     <= {vld_r[STAGE_CNT-2:0], in_ch.valid};
      out_vld_r <= vld_r[STAGE_CNT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cmd_r[0] <= cmd_e_t'(in_ch.command);
      for (int i = 1; i < STAGE_CNT; i++) begin
        cmd_r[i] <= cmd_r[i-1];
      end
    end
  end

  // pick the result of the command at the tail
  always_comb begin
    cnt_nxt = '0;
    case (cmd_r[STAGE_CNT-1])
      CMD_ADD: begin
        val_nxt = ar.add_val;
        flg_nxt = ar.add_flg;
      end
      CMD_MUL: begin
        val_nxt = ar.mul_val;
        flg_nxt = ar.mul_flg;
      end
      CMD_MAC: begin
        val_nxt = ar.mac_val;
        flg_nxt = ar.mac_flg;
      end
      default: begin
        val_nxt = er.val;
        cnt_nxt = er.count;
        flg_nxt = er.flg;
      end
    endcase
  end

  // hold the result until taken
  always_ff @(posedge clk) begin
    if (adv) begin
      val_r <= val_nxt;
      cnt_r <= cnt_nxt;
      flg_r <= flg_nxt;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.result_value = val_r;
  assign out_ch.emit_count   = cnt_r;
  assign out_ch.status_flags = flg_r;

`ifndef SYNTHESIS
  // an accepted beat enters the first stage
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> vld_r[0])
    else $error("accepted beat did not enter the pipeline");

  // a stall freezes every valid bit
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(vld_r) && out_vld_r))
    else $error("pipeline moved during a stall");

  // emit errors give a zero count
  a_err_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (flg_r[FLG_DIVZ] || flg_r[FLG_RANGE])) |-> (cnt_r == '0))
    else $error("emit error with non-zero count");

  // emit flags never mix with arithmetic flags
  a_flag_mix: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (flg_r[FLG_DIVZ] || flg_r[FLG_RANGE] || flg_r[FLG_CROP]))
      |-> (!flg_r[FLG_SAT] && !flg_r[FLG_TRUNC]))
    else $error("emit and arithmetic flags set together");
`endif

endmodule
